>>> rtl/iap_pkg.sv
// Package for the integer ALU with power.
// Holds the operation and status codes, the multiplier digit width and the
// command and status structs between controller and datapath. No dependencies.
package iap_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int DIGIT_W = 8;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4,
		OP_POW = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DIV_ZERO  = 3'd1,
		ST_REM_ZERO  = 3'd2,
		ST_ZERO_ZERO = 3'd3,
		ST_NEG_EXP   = 3'd4
	} status_t;

	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_step;
		logic pow_launch;
		logic pow_update;
		logic write_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic err;
		logic exp_zero;
	} sts_t;

endpackage

>>> rtl/iap_in_if.sv
// Input channel of the integer ALU: valid/ready handshake with the operation
// and both operands. Depends on iap_pkg.
interface iap_in_if import iap_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
	logic                  valid;
	logic                  ready;
	logic [2:0]            operation;
	logic [DATA_WIDTH-1:0] left_operand;
	logic [DATA_WIDTH-1:0] right_operand;

	modport source (output valid, output operation, output left_operand,
		output right_operand, input ready);
	modport sink (input valid, input operation, input left_operand,
		input right_operand, output ready);
endinterface

>>> rtl/iap_out_if.sv
// Output channel of the integer ALU: valid/ready handshake with the result
// and its status. Depends on iap_pkg.
interface iap_out_if import iap_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] result;
	logic [2:0]            status;

	modport source (output valid, output result, output status, input ready);
	modport sink (input valid, input result, input status, output ready);
endinterface

>>> rtl/iap_mul.sv
// Digit-serial multiplier lane: one DIGIT_W-bit digit of the multiplier per
// step, product kept modulo 2^DATA_WIDTH. Depends on iap_pkg.
module iap_mul import iap_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic                  step,
	input  logic [DATA_WIDTH-1:0] mcand,
	input  logic [DATA_WIDTH-1:0] mplier,
	output logic [DATA_WIDTH-1:0] product
);

	localparam int PART_W = DATA_WIDTH + DIGIT_W;

	logic [DATA_WIDTH-1:0] mcand_q;
	logic [DATA_WIDTH-1:0] mplier_q;
	logic [DATA_WIDTH-1:0] prod_q;
	logic [PART_W-1:0]     part;

	assign part = {{DIGIT_W{1'b0}}, mcand_q} *
		{{DATA_WIDTH{1'b0}}, mplier_q[DIGIT_W-1:0]};

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q   <= '0;
			mcand_q  <= mcand;
			mplier_q <= mplier;
		end else if (step) begin
			prod_q   <= prod_q + part[DATA_WIDTH-1:0];
			mcand_q  <= mcand_q << DIGIT_W;
			mplier_q <= mplier_q >> DIGIT_W;
		end
	end

	assign product = prod_q;

endmodule

>>> rtl/iap_dp.sv
// Datapath of the integer ALU: operand registers, restoring divider, power
// registers, two multiplier lanes and the output register.
// Depends on iap_pkg and iap_mul.
module iap_dp import iap_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  cmd_t                  cmd,
	input  logic [2:0]            operation,
	input  logic [DATA_WIDTH-1:0] left_operand,
	input  logic [DATA_WIDTH-1:0] right_operand,
	output sts_t                  sts,
	output logic [DATA_WIDTH-1:0] result,
	output logic [2:0]            status
);

	localparam int W = DATA_WIDTH;

	op_t         op_q;
	logic [W-1:0] a_q;
	logic [W-1:0] b_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] base_q;
	logic [W-1:0] exp_q;
	logic [W:0]   rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dvs_q;
	logic [W-1:0] res_q;
	status_t      st_q;

	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W:0]   rem_sh;
	logic [W:0]   rem_diff;
	logic         lane_x_load;
	logic [W-1:0] lane_x_mcand;
	logic [W-1:0] lane_x_mplier;
	logic [W-1:0] prod_x;
	logic [W-1:0] prod_y;
	status_t      status_c;
	logic [W-1:0] result_c;

	assign a_mag = left_operand[W-1] ? ('0 - left_operand) : left_operand;
	assign b_mag = right_operand[W-1] ? ('0 - right_operand) : right_operand;

	assign lane_x_load   = cmd.load | cmd.pow_launch;
	assign lane_x_mcand  = cmd.load ? left_operand : acc_q;
	assign lane_x_mplier = cmd.load ? right_operand : base_q;

	iap_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul_x (
		.clk     (clk),
		.load    (lane_x_load),
		.step    (cmd.mul_step),
		.mcand   (lane_x_mcand),
		.mplier  (lane_x_mplier),
		.product (prod_x)
	);

	iap_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul_y (
		.clk     (clk),
		.load    (cmd.pow_launch),
		.step    (cmd.mul_step),
		.mcand   (base_q),
		.mplier  (base_q),
		.product (prod_y)
	);

	assign rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(operation);
			a_q    <= left_operand;
			b_q    <= right_operand;
			acc_q  <= {{(W-1){1'b0}}, 1'b1};
			base_q <= left_operand;
			exp_q  <= right_operand;
			rem_q  <= '0;
			quo_q  <= a_mag;
			dvs_q  <= b_mag;
		end else begin
			if (cmd.div_step) begin
				if (!rem_diff[W]) begin
					rem_q <= rem_diff;
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
			end
			if (cmd.pow_update) begin
				acc_q  <= exp_q[0] ? prod_x : acc_q;
				base_q <= prod_y;
				exp_q  <= exp_q >> 1;
			end
		end
		if (cmd.write_out) begin
			res_q <= result_c;
			st_q  <= status_c;
		end
	end

	always_comb begin
		status_c = ST_OK;
		case (op_q)
			OP_DIV: begin
				if (b_q == '0) status_c = ST_DIV_ZERO;
			end
			OP_REM: begin
				if (b_q == '0) status_c = ST_REM_ZERO;
			end
			OP_POW: begin
				if (a_q == '0 && b_q == '0) status_c = ST_ZERO_ZERO;
				else if (b_q[W-1]) status_c = ST_NEG_EXP;
			end
			default: status_c = ST_OK;
		endcase
	end

	always_comb begin
		result_c = '0;
		case (op_q)
			OP_ADD: result_c = a_q + b_q;
			OP_SUB: result_c = a_q - b_q;
			OP_MUL: result_c = prod_x;
			OP_DIV: result_c = (a_q[W-1] ^ b_q[W-1]) ? ('0 - quo_q) : quo_q;
			OP_REM: result_c = a_q[W-1] ? ('0 - rem_q[W-1:0]) : rem_q[W-1:0];
			OP_POW: result_c = acc_q;
			default: result_c = '0;
		endcase
		if (status_c != ST_OK) result_c = '0;
	end

	assign sts.op       = op_q;
	assign sts.err      = (status_c != ST_OK);
	assign sts.exp_zero = (exp_q == '0);

	assign result = res_q;
	assign status = st_q;

endmodule

>>> rtl/iap_ctrl.sv
// Controller of the integer ALU: sequences the datapath for each operation
// and owns the input and output handshakes. Depends on iap_pkg.
module iap_ctrl import iap_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int NDIG = (DATA_WIDTH + DIGIT_W - 1) / DIGIT_W;
	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_MUL,
		S_DIV,
		S_POW_CHECK,
		S_POW_MUL,
		S_POW_UPD,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:      cmd.load = in_valid;
			S_MUL:       cmd.mul_step = 1'b1;
			S_DIV:       cmd.div_step = 1'b1;
			S_POW_CHECK: cmd.pow_launch = !sts.exp_zero;
			S_POW_MUL:   cmd.mul_step = 1'b1;
			S_POW_UPD:   cmd.pow_update = 1'b1;
			S_FINISH:    cmd.write_out = !out_valid_q || out_ready;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (sts.err) begin
						state_q <= S_FINISH;
					end else begin
						case (sts.op)
							OP_MUL: begin
								cnt_q   <= CNT_W'(NDIG - 1);
								state_q <= S_MUL;
							end
							OP_DIV, OP_REM: begin
								cnt_q   <= CNT_W'(DATA_WIDTH - 1);
								state_q <= S_DIV;
							end
							OP_POW: state_q <= S_POW_CHECK;
							default: state_q <= S_FINISH;
						endcase
					end
				end
				S_MUL, S_DIV: begin
					if (cnt_q == '0) state_q <= S_FINISH;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_POW_CHECK: begin
					if (sts.exp_zero) begin
						state_q <= S_FINISH;
					end else begin
						cnt_q   <= CNT_W'(NDIG - 1);
						state_q <= S_POW_MUL;
					end
				end
				S_POW_MUL: begin
					if (cnt_q == '0) state_q <= S_POW_UPD;
					else cnt_q <= cnt_q - 1'b1;
				end
				S_POW_UPD: state_q <= S_POW_CHECK;
				S_FINISH: begin
					if (cmd.write_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/integer_alu_with_power.sv
// Top level of the integer ALU with power: joins controller and datapath to
// the two channels. Depends on iap_pkg, iap_in_if, iap_out_if, iap_ctrl, iap_dp.
//
//   channel  direction  payload
//   in_ch    sink       operation, left_operand, right_operand
//   out_ch   source     result, status
//
// One item at a time. Add, subtract, unused codes and errors go from dispatch
// straight to the output register; multiply works through the multiplier one
// 8-bit digit per cycle (NDIG = DATA_WIDTH/8 digits, rounded up); divide and
// remainder give one quotient bit per cycle; power runs one square-and-multiply
// round per exponent bit, up to and including the highest set bit.
// The next item is accepted in the cycle after the result enters the output
// register, even while that result waits to be taken.
// Reset is asynchronous and clears only the control state.
module integer_alu_with_power import iap_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	iap_in_if.sink    in_ch,
	iap_out_if.source out_ch
);

	cmd_t cmd;
	sts_t sts;

	iap_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	iap_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.operation     (in_ch.operation),
		.left_operand  (in_ch.left_operand),
		.right_operand (in_ch.right_operand),
		.sts           (sts),
		.result        (out_ch.result),
		.status        (out_ch.status)
	);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.result == '0))
		else $error("error status with nonzero result");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("item accepted while another is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |-> (!out_ch.valid || out_ch.ready))
		else $error("output register overwritten before it was taken");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for integer_alu_with_power: a directed table, then random items
// under several idling phases; results are checked against typed values or a
// local predictor. Depends on iap_pkg, iap_in_if, iap_out_if and the top RTL.
module testbench;
	import iap_pkg::*;

	localparam int W = DATA_WIDTH_DEF;
	localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MAX_VAL = ~MIN_VAL;
	localparam logic [W-1:0] ALL_ONES = '1;
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int PHASE_ITEMS = 150;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic [W-1:0] result;
		status_t      status;
	} alu_out_t;

	typedef struct packed {
		logic [2:0]   op;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic         typed;
		alu_out_t     want;
	} vector_t;

	logic clk;
	logic arst_n;

	iap_in_if #(.DATA_WIDTH(W)) in_ch ();
	iap_out_if #(.DATA_WIDTH(W)) out_ch ();

	integer_alu_with_power #(.DATA_WIDTH(W)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	alu_out_t pending_results[$];
	vector_t directed_rows[$];
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int quiet_cycles = 0;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic alu_out_t predict_node(input logic [2:0] op, input logic [W-1:0] a,
		input logic [W-1:0] b);
		alu_out_t r;
		logic [W-1:0] ma;
		logic [W-1:0] mb;
		logic [W-1:0] q;
		logic [W-1:0] base;
		logic [W-1:0] acc;
		r.result = '0;
		r.status = ST_OK;
		ma = a[W-1] ? -a : a;
		mb = b[W-1] ? -b : b;
		case (op)
			OP_ADD: r.result = a + b;
			OP_SUB: r.result = a - b;
			OP_MUL: r.result = a * b;
			OP_DIV: begin
				if (b == '0) begin
					r.status = ST_DIV_ZERO;
				end else begin
					q = ma / mb;
					r.result = (a[W-1] ^ b[W-1]) ? -q : q;
				end
			end
			OP_REM: begin
				if (b == '0) begin
					r.status = ST_REM_ZERO;
				end else begin
					q = ma % mb;
					r.result = a[W-1] ? -q : q;
				end
			end
			OP_POW: begin
				if (a == '0 && b == '0) begin
					r.status = ST_ZERO_ZERO;
				end else if (b[W-1]) begin
					r.status = ST_NEG_EXP;
				end else begin
					acc = 1;
					base = a;
					for (int i = 0; i < W; i++) begin
						if (b[i])
							acc = acc * base;
						base = base * base;
					end
					r.result = acc;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic vector_t make_row(input logic [2:0] op, input logic [W-1:0] a,
		input logic [W-1:0] b, input logic typed, input logic [W-1:0] res, input status_t st);
		vector_t v;
		v.op = op;
		v.a = a;
		v.b = b;
		v.typed = typed;
		v.want.result = res;
		v.want.status = st;
		return v;
	endfunction

	function automatic logic [W-1:0] pick_operand();
		logic [W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = 1;
			2: v = ALL_ONES;
			3: v = MIN_VAL;
			4: v = MAX_VAL;
			5: v = $urandom_range(0, 200) - 100;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic send_item(input logic [2:0] op, input logic [W-1:0] a,
		input logic [W-1:0] b, input alu_out_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.left_operand <= a;
		in_ch.right_operand <= b;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		pending_results.push_back(want);
		@(negedge clk);
	endtask

	initial begin
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_result
		alu_out_t want;
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h status %0d", $time, out_ch.result,
					out_ch.status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.result !== want.result) begin
					$display("%0t: result expected %h actual %h", $time, want.result,
						out_ch.result);
					error_count++;
				end
				if (out_ch.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						out_ch.status);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		vector_t row;
		logic [2:0] op;
		logic [W-1:0] a;
		logic [W-1:0] b;
		int pick;
		in_ch.valid <= 1'b0;
		in_ch.operation <= '0;
		in_ch.left_operand <= '0;
		in_ch.right_operand <= '0;
		arst_n = 1'b0;

		directed_rows.push_back(make_row(OP_ADD, '0, '0, 1'b1, '0, ST_OK));
		directed_rows.push_back(make_row(OP_ADD, MAX_VAL, 1, 1'b1, MIN_VAL, ST_OK));
		directed_rows.push_back(make_row(OP_SUB, MIN_VAL, 1, 1'b1, MAX_VAL, ST_OK));
		directed_rows.push_back(make_row(OP_SUB, '0, MIN_VAL, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_MUL, MAX_VAL, MAX_VAL, 1'b1, 1, ST_OK));
		directed_rows.push_back(make_row(OP_MUL, MIN_VAL, ALL_ONES, 1'b1, MIN_VAL, ST_OK));
		directed_rows.push_back(make_row(OP_DIV, 7, '0, 1'b1, '0, ST_DIV_ZERO));
		directed_rows.push_back(make_row(OP_REM, 7, '0, 1'b1, '0, ST_REM_ZERO));
		directed_rows.push_back(make_row(OP_DIV, MIN_VAL, ALL_ONES, 1'b1, MIN_VAL, ST_OK));
		directed_rows.push_back(make_row(OP_REM, MIN_VAL, ALL_ONES, 1'b1, '0, ST_OK));
		directed_rows.push_back(make_row(OP_DIV, -7, 2, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_REM, -7, 2, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_REM, 7, -2, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_DIV, MAX_VAL, MIN_VAL, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_DIV, MIN_VAL, 1, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_POW, '0, '0, 1'b1, '0, ST_ZERO_ZERO));
		directed_rows.push_back(make_row(OP_POW, '0, ALL_ONES, 1'b1, '0, ST_NEG_EXP));
		directed_rows.push_back(make_row(OP_POW, 2, MIN_VAL, 1'b1, '0, ST_NEG_EXP));
		directed_rows.push_back(make_row(OP_POW, 5, '0, 1'b1, 1, ST_OK));
		directed_rows.push_back(make_row(OP_POW, '0, 5, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_POW, 2, W - 1, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_POW, 3, MAX_VAL, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_POW, ALL_ONES, MAX_VAL, 1'b0, '0, ST_OK));
		directed_rows.push_back(make_row(OP_SPARE_LO, MAX_VAL, MAX_VAL, 1'b1, '0, ST_OK));
		directed_rows.push_back(make_row(OP_SPARE_HI, MIN_VAL, ALL_ONES, 1'b1, '0, ST_OK));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_item(row.op, row.a, row.b,
				row.typed ? row.want : predict_node(row.op, row.a, row.b));
		end

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 54; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 54; end
				default: begin send_idle_pct = 35; recv_stall_pct = 35; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 0 && n == 20)
					hold_requests++;
				if ($urandom_range(0, 99) < 4)
					op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				else
					op = 3'($urandom_range(OP_ADD, OP_POW));
				a = pick_operand();
				b = pick_operand();
				if ((op == OP_DIV || op == OP_REM) && $urandom_range(0, 99) < 8)
					b = '0;
				if (op == OP_POW) begin
					pick = $urandom_range(0, 9);
					if (pick < 6)
						b = $urandom_range(0, 40);
					else if (pick < 8)
						b = $urandom & MAX_VAL;
					else if (pick < 9)
						b = $urandom | MIN_VAL;
					if ($urandom_range(0, 19) == 0)
						a = '0;
				end
				send_item(op, a, b, predict_node(op, a, b));
			end
		end
		in_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
